// ===== rtl/gcaim_pkg.sv =====
// Shared types, constants and helpers for the grid cell active index map.
// Used by gcaim_unit, gcaim_table and grid_cell_active_index_map.
// No dependencies.
`default_nettype none

package gcaim_pkg;

  // Table geometry.
  localparam int MAX_CELLS = 65536;
  localparam int ADDR_W    = $clog2(MAX_CELLS);

  // Field and datapath widths.
  localparam int CELL_W = 16;
  localparam int SIZE_W = 17;
  localparam int NUM_W  = 17;
  localparam int PROD_W = 2 * SIZE_W;

  // The restoring divider retires one quotient bit per step.
  localparam int DIV_STEPS = CELL_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [NUM_W-1:0] NEG_ONE = '1;

  // Operation codes.
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // Neighbour directions.
  localparam logic [1:0] DIR_I    = 2'd0;
  localparam logic [1:0] DIR_J    = 2'd1;
  localparam logic [1:0] DIR_K    = 2'd2;
  localparam logic [1:0] DIR_NONE = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_SIZE_I = 2'd0;
  localparam logic [1:0] REG_SIZE_J = 2'd1;
  localparam logic [1:0] REG_SIZE_K = 2'd2;

  typedef enum logic [3:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_MUL_IJ,
    ST_MUL_K,
    ST_DECIDE,
    ST_DIV_I,
    ST_DIVJ_LOAD,
    ST_DIV_J,
    ST_NBR,
    ST_RD_NB
  } state_t;

  typedef enum logic [1:0] {
    UC_IDLE,
    UC_MUL,
    UC_DIV_LOAD,
    UC_DIV_STEP
  } unit_cmd_t;

  typedef struct packed {
    unit_cmd_t         cmd;
    logic [SIZE_W-1:0] a;
    logic [SIZE_W-1:0] b;
  } unit_req_t;

  typedef struct packed {
    logic [PROD_W-1:0] prod;
    logic [SIZE_W-1:0] rem;
    logic [CELL_W-1:0] quo;
  } unit_rsp_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [NUM_W-1:0]  wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } table_req_t;

  // Grid size limited to the table capacity.
  function automatic logic [SIZE_W-1:0] cap_cells(input logic [PROD_W-1:0] x);
    logic [SIZE_W-1:0] r;
    if (x > PROD_W'(MAX_CELLS)) begin
      r = SIZE_W'(MAX_CELLS);
    end else begin
      r = x[SIZE_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/gcaim_unit.sv =====
// Shared arithmetic unit: a registered 17x17 multiplier and a restoring
// divider that retires one quotient bit per step. Depends on gcaim_pkg.
`default_nettype none

module gcaim_unit (
  input  wire logic                 clk,
  input  wire gcaim_pkg::unit_req_t req,
  output gcaim_pkg::unit_rsp_t      rsp
);

  logic [gcaim_pkg::PROD_W-1:0] prod;
  logic [gcaim_pkg::SIZE_W-1:0] rem;
  logic [gcaim_pkg::CELL_W-1:0] quo;
  logic [gcaim_pkg::SIZE_W-1:0] dvs;
  logic [gcaim_pkg::PROD_W-1:0] mul_full;
  logic [gcaim_pkg::SIZE_W+1:0] trial;

  assign mul_full = req.a * req.b;

  // Shift in the next dividend bit and try to subtract the divisor.
  assign trial = {1'b0, rem, quo[gcaim_pkg::CELL_W-1]} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    case (req.cmd)
      gcaim_pkg::UC_MUL: begin
        prod <= mul_full;
      end
      gcaim_pkg::UC_DIV_LOAD: begin
        rem <= '0;
        quo <= req.a[gcaim_pkg::CELL_W-1:0];
        dvs <= req.b;
      end
      gcaim_pkg::UC_DIV_STEP: begin
        if (!trial[gcaim_pkg::SIZE_W+1]) begin
          rem <= trial[gcaim_pkg::SIZE_W-1:0];
          quo <= {quo[gcaim_pkg::CELL_W-2:0], 1'b1};
        end else begin
          rem <= {rem[gcaim_pkg::SIZE_W-2:0], quo[gcaim_pkg::CELL_W-1]};
          quo <= {quo[gcaim_pkg::CELL_W-2:0], 1'b0};
        end
      end
      default: begin
      end
    endcase
  end

  assign rsp.prod = prod;
  assign rsp.rem  = rem;
  assign rsp.quo  = quo;

endmodule

`default_nettype wire

// ===== rtl/gcaim_table.sv =====
// Active number table: one write port and one read port with registered
// read data. Depends on gcaim_pkg.
`default_nettype none

module gcaim_table (
  input  wire logic                   clk,
  input  wire gcaim_pkg::table_req_t  req,
  output logic [gcaim_pkg::NUM_W-1:0] rd_data
);

  logic [gcaim_pkg::NUM_W-1:0] mem [gcaim_pkg::MAX_CELLS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/grid_cell_active_index_map.sv =====
// Top level of the grid cell active index map: sequencer, size registers
// and result registers. Depends on gcaim_pkg, gcaim_unit and gcaim_table.
`default_nettype none

// The block keeps a 65536-entry table that gives each global cell of a
// size_i by size_j by size_k grid its active number, or -1. A word is taken
// at a clock edge where start is high and busy is low; the block then stays
// busy until its result is out, one word at a time. Every word yields exactly
// one result, shown for a single cycle with done high; the receiver cannot
// stall it, so it must take the result in that cycle. A load or any word
// whose cell is off the grid passes through ST_MUL_IJ and ST_MUL_K, where the
// shared multiplier forms the grid size, capped at the table capacity, and
// ST_DECIDE, which decides and, for a load, writes. A query on the grid goes
// on through ST_DIV_I, ST_DIVJ_LOAD, ST_DIV_J, ST_NBR and, when the neighbour
// is on the grid and its entry has to be read, ST_RD_NB: the shared unit runs
// two 16-step restoring divisions (cell by size_i, then that quotient by
// size_j) to split the cell into i, j and k, and the table's single read port
// is used once for the cell and once for the neighbour. A clear refills the
// table one entry per cycle through all 65536 entries before its result
// appears. After reset the same fill runs with busy high and no result. Size
// registers may be written at any time through cfg_write, cfg_index and
// cfg_data, but should only change while the block is idle.

module grid_cell_active_index_map (
  input  wire  logic                          clk,
  input  wire  logic                          rst,
  input  wire  logic                          start,
  output logic                                busy,
  input  wire  logic [1:0]                    op,
  input  wire  logic [gcaim_pkg::CELL_W-1:0]  global_cell,
  input  wire  logic [1:0]                    direction,
  output logic                                done,
  output logic signed [gcaim_pkg::NUM_W-1:0]  active_number,
  output logic signed [gcaim_pkg::NUM_W-1:0]  neighbour_number,
  input  wire  logic                          cfg_write,
  input  wire  logic [1:0]                    cfg_index,
  input  wire  logic [gcaim_pkg::SIZE_W-1:0]  cfg_data
);

  gcaim_pkg::state_t state;
  gcaim_pkg::state_t state_next;

  logic [gcaim_pkg::SIZE_W-1:0] size_i;
  logic [gcaim_pkg::SIZE_W-1:0] size_j;
  logic [gcaim_pkg::SIZE_W-1:0] size_k;

  logic [1:0]                   op_reg;
  logic [gcaim_pkg::CELL_W-1:0] cell_reg;
  logic [1:0]                   dir_reg;
  logic [gcaim_pkg::STEP_W-1:0] step;
  logic [gcaim_pkg::SIZE_W-1:0] grid_n;
  logic [gcaim_pkg::PROD_W-1:0] p_ij;
  logic [gcaim_pkg::CELL_W-1:0] i_reg;
  logic [gcaim_pkg::NUM_W-1:0]  act_reg;
  logic [gcaim_pkg::NUM_W-1:0]  next_active;
  logic [gcaim_pkg::ADDR_W-1:0] sweep_addr;
  logic                         clr_reply;

  gcaim_pkg::unit_req_t  unit_req;
  gcaim_pkg::unit_rsp_t  unit_rsp;
  gcaim_pkg::table_req_t tbl_req;
  logic [gcaim_pkg::NUM_W-1:0] rd_data;

  // Decision and neighbour terms.
  logic [gcaim_pkg::SIZE_W-1:0] n_now;
  logic                         cell_in;
  logic                         load_ok;
  logic                         sweep_last;
  logic                         step_last;
  logic                         axis_ok;
  logic [gcaim_pkg::PROD_W-1:0] stride;
  logic [gcaim_pkg::PROD_W-1:0] nb_cell;
  logic                         nb_ok;

  gcaim_unit u_unit (
    .clk (clk),
    .req (unit_req),
    .rsp (unit_rsp)
  );

  gcaim_table u_table (
    .clk     (clk),
    .req     (tbl_req),
    .rd_data (rd_data)
  );

  // In the decide state the unit holds the product of the capped size_i*size_j and size_k.
  assign n_now      = gcaim_pkg::cap_cells(unit_rsp.prod);
  assign cell_in    = {1'b0, cell_reg} < n_now;
  assign load_ok    = cell_in && !next_active[gcaim_pkg::NUM_W-1];
  assign sweep_last = sweep_addr == gcaim_pkg::ADDR_W'(gcaim_pkg::MAX_CELLS - 1);
  assign step_last  = step == gcaim_pkg::STEP_W'(gcaim_pkg::DIV_STEPS - 1);

  // After the second division the unit holds j as remainder and k as quotient.
  // A step up along an axis that stays inside the grid moves the linear index
  // by that axis's stride.
  always_comb begin
    axis_ok = 1'b0;
    stride  = '0;
    case (dir_reg)
      gcaim_pkg::DIR_I: begin
        axis_ok = ({1'b0, i_reg} + 17'd1) < size_i;
        stride  = gcaim_pkg::PROD_W'(1);
      end
      gcaim_pkg::DIR_J: begin
        axis_ok = (unit_rsp.rem + 17'd1) < size_j;
        stride  = gcaim_pkg::PROD_W'(size_i);
      end
      gcaim_pkg::DIR_K: begin
        axis_ok = ({1'b0, unit_rsp.quo} + 17'd1) < size_k;
        stride  = p_ij;
      end
      gcaim_pkg::DIR_NONE: begin
        axis_ok = 1'b0;
      end
      default: begin
        axis_ok = 1'b0;
      end
    endcase
  end

  assign nb_cell = gcaim_pkg::PROD_W'(cell_reg) + stride;
  assign nb_ok   = axis_ok && (nb_cell < gcaim_pkg::PROD_W'(grid_n));

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      gcaim_pkg::ST_SWEEP: begin
        if (sweep_last) begin
          state_next = gcaim_pkg::ST_IDLE;
        end
      end
      gcaim_pkg::ST_IDLE: begin
        if (start) begin
          if (op == gcaim_pkg::OP_CLEAR) begin
            state_next = gcaim_pkg::ST_SWEEP;
          end else begin
            state_next = gcaim_pkg::ST_MUL_IJ;
          end
        end
      end
      gcaim_pkg::ST_MUL_IJ: begin
        state_next = gcaim_pkg::ST_MUL_K;
      end
      gcaim_pkg::ST_MUL_K: begin
        state_next = gcaim_pkg::ST_DECIDE;
      end
      gcaim_pkg::ST_DECIDE: begin
        if (op_reg == gcaim_pkg::OP_QUERY && cell_in) begin
          state_next = gcaim_pkg::ST_DIV_I;
        end else begin
          state_next = gcaim_pkg::ST_IDLE;
        end
      end
      gcaim_pkg::ST_DIV_I: begin
        if (step_last) begin
          state_next = gcaim_pkg::ST_DIVJ_LOAD;
        end
      end
      gcaim_pkg::ST_DIVJ_LOAD: begin
        state_next = gcaim_pkg::ST_DIV_J;
      end
      gcaim_pkg::ST_DIV_J: begin
        if (step_last) begin
          state_next = gcaim_pkg::ST_NBR;
        end
      end
      gcaim_pkg::ST_NBR: begin
        if (nb_ok) begin
          state_next = gcaim_pkg::ST_RD_NB;
        end else begin
          state_next = gcaim_pkg::ST_IDLE;
        end
      end
      gcaim_pkg::ST_RD_NB: begin
        state_next = gcaim_pkg::ST_IDLE;
      end
      default: begin
        state_next = gcaim_pkg::ST_IDLE;
      end
    endcase
  end

  // Unit commands, table accesses and the busy flag.
  always_comb begin
    busy           = state != gcaim_pkg::ST_IDLE;
    unit_req.cmd   = gcaim_pkg::UC_IDLE;
    unit_req.a     = '0;
    unit_req.b     = '0;
    tbl_req.we     = 1'b0;
    tbl_req.waddr  = cell_reg;
    tbl_req.wdata  = next_active;
    tbl_req.re     = 1'b0;
    tbl_req.raddr  = cell_reg;
    case (state)
      gcaim_pkg::ST_SWEEP: begin
        tbl_req.we    = 1'b1;
        tbl_req.waddr = sweep_addr;
        tbl_req.wdata = gcaim_pkg::NEG_ONE;
      end
      gcaim_pkg::ST_MUL_IJ: begin
        unit_req.cmd = gcaim_pkg::UC_MUL;
        unit_req.a   = size_i;
        unit_req.b   = size_j;
      end
      gcaim_pkg::ST_MUL_K: begin
        // Capping before the last product keeps it at 34 bits and does not
        // change the capped grid size.
        unit_req.cmd = gcaim_pkg::UC_MUL;
        unit_req.a   = gcaim_pkg::cap_cells(unit_rsp.prod);
        unit_req.b   = size_k;
      end
      gcaim_pkg::ST_DECIDE: begin
        if (op_reg == gcaim_pkg::OP_LOAD && load_ok) begin
          tbl_req.we = 1'b1;
        end
        if (op_reg == gcaim_pkg::OP_QUERY && cell_in) begin
          unit_req.cmd = gcaim_pkg::UC_DIV_LOAD;
          unit_req.a   = {1'b0, cell_reg};
          unit_req.b   = size_i;
          tbl_req.re   = 1'b1;
        end
      end
      gcaim_pkg::ST_DIV_I, gcaim_pkg::ST_DIV_J: begin
        unit_req.cmd = gcaim_pkg::UC_DIV_STEP;
      end
      gcaim_pkg::ST_DIVJ_LOAD: begin
        unit_req.cmd = gcaim_pkg::UC_DIV_LOAD;
        unit_req.a   = {1'b0, unit_rsp.quo};
        unit_req.b   = size_j;
      end
      gcaim_pkg::ST_NBR: begin
        tbl_req.re    = nb_ok;
        tbl_req.raddr = nb_cell[gcaim_pkg::ADDR_W-1:0];
      end
      default: begin
      end
    endcase
  end

  // Control registers and size registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= gcaim_pkg::ST_SWEEP;
      sweep_addr  <= '0;
      next_active <= '0;
      clr_reply   <= 1'b0;
      done        <= 1'b0;
      step        <= '0;
      size_i      <= gcaim_pkg::SIZE_W'(1);
      size_j      <= gcaim_pkg::SIZE_W'(1);
      size_k      <= gcaim_pkg::SIZE_W'(1);
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (cfg_write) begin
        case (cfg_index)
          gcaim_pkg::REG_SIZE_I: size_i <= cfg_data;
          gcaim_pkg::REG_SIZE_J: size_j <= cfg_data;
          gcaim_pkg::REG_SIZE_K: size_k <= cfg_data;
          default: begin
          end
        endcase
      end
      case (state)
        gcaim_pkg::ST_SWEEP: begin
          sweep_addr <= sweep_addr + 1'b1;
          if (sweep_last) begin
            done      <= clr_reply;
            clr_reply <= 1'b0;
          end
        end
        gcaim_pkg::ST_IDLE: begin
          if (start && op == gcaim_pkg::OP_CLEAR) begin
            clr_reply   <= 1'b1;
            sweep_addr  <= '0;
            next_active <= '0;
          end
        end
        gcaim_pkg::ST_DECIDE: begin
          step <= '0;
          if (op_reg == gcaim_pkg::OP_LOAD && load_ok) begin
            next_active <= next_active + 1'b1;
          end
          if (!(op_reg == gcaim_pkg::OP_QUERY && cell_in)) begin
            done <= 1'b1;
          end
        end
        gcaim_pkg::ST_DIV_I, gcaim_pkg::ST_DIV_J: begin
          step <= step + 1'b1;
        end
        gcaim_pkg::ST_NBR: begin
          done <= !nb_ok;
        end
        gcaim_pkg::ST_RD_NB: begin
          done <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    case (state)
      gcaim_pkg::ST_SWEEP: begin
        active_number    <= $signed(gcaim_pkg::NEG_ONE);
        neighbour_number <= $signed(gcaim_pkg::NEG_ONE);
      end
      gcaim_pkg::ST_IDLE: begin
        if (start) begin
          op_reg   <= op;
          cell_reg <= global_cell;
          dir_reg  <= direction;
        end
      end
      gcaim_pkg::ST_MUL_K: begin
        p_ij <= unit_rsp.prod;
      end
      gcaim_pkg::ST_DECIDE: begin
        grid_n           <= n_now;
        neighbour_number <= $signed(gcaim_pkg::NEG_ONE);
        if (op_reg == gcaim_pkg::OP_LOAD && load_ok) begin
          active_number <= $signed(next_active);
        end else begin
          active_number <= $signed(gcaim_pkg::NEG_ONE);
        end
      end
      gcaim_pkg::ST_DIV_I: begin
        // The cell's own entry was read in the decide state.
        if (step == '0) begin
          act_reg <= rd_data;
        end
      end
      gcaim_pkg::ST_DIVJ_LOAD: begin
        i_reg <= unit_rsp.rem[gcaim_pkg::CELL_W-1:0];
      end
      gcaim_pkg::ST_NBR: begin
        active_number    <= $signed(act_reg);
        neighbour_number <= $signed(gcaim_pkg::NEG_ONE);
      end
      gcaim_pkg::ST_RD_NB: begin
        active_number    <= $signed(act_reg);
        neighbour_number <= $signed(rd_data);
      end
      default: begin
      end
    endcase
  end

  // An accepted word always keeps the block busy in the next cycle.
  assert property (@(posedge clk) disable iff (rst) start && !busy |=> busy)
    else $error("block not busy after accepting a word");

  // A result appears only as the sequencer returns to idle.
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // Numbering only advances by one or restarts at zero.
  assert property (@(posedge clk) disable iff (rst)
    !$stable(next_active) |->
      (next_active == '0) || (next_active == $past(next_active) + 17'd1))
    else $error("active numbering jumped");

  // The neighbour read is only made for a query.
  assert property (@(posedge clk) disable iff (rst)
    state == gcaim_pkg::ST_RD_NB |-> op_reg == gcaim_pkg::OP_QUERY)
    else $error("neighbour read outside a query");

endmodule

`default_nettype wire
